[design/mlr_pkg.sv]
`default_nettype none

package mlr_pkg;

  typedef enum logic [2:0] {
    MODE_VERT         = 3'd0,
    MODE_HORZ         = 3'd1,
    MODE_SHALLOW_UP   = 3'd2,
    MODE_SHALLOW_DOWN = 3'd3,
    MODE_STEEP_UP     = 3'd4,
    MODE_STEEP_DOWN   = 3'd5
  } mode_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  // Segment control produced by the setup logic
  typedef struct packed {
    mode_t mode;
    logic  active;
    logic  last;
  } seg_ctl_t;

  // Extra error-term bits above the coordinate width
  localparam int unsigned ERR_EXTRA = 3;

endpackage

`default_nettype wire

[design/mlr_setup.sv]
`default_nettype none

module mlr_setup #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned ERR_W      = 13
) (
  input  wire logic [COORD_BITS-1:0] x_a,
  input  wire logic [COORD_BITS-1:0] y_a,
  input  wire logic [COORD_BITS-1:0] x_b,
  input  wire logic [COORD_BITS-1:0] y_b,
  output logic [COORD_BITS-1:0]      first_x,
  output logic [COORD_BITS-1:0]      first_y,
  output logic [COORD_BITS-1:0]      stop,
  output logic [COORD_BITS-1:0]      dx,
  output logic [COORD_BITS-1:0]      dy,
  output logic signed [ERR_W-1:0]    err,
  output mlr_pkg::seg_ctl_t          ctl
);

  logic [COORD_BITS-1:0] xs, ys, xe, ye;
  logic                  rising;
  logic signed [ERR_W-1:0] dxe, dye;

  always_comb begin
    // Order endpoints so that x does not decrease; vertical runs bottom up
    if (x_a > x_b) begin
      xs = x_b; ys = y_b; xe = x_a; ye = y_a;
    end else begin
      xs = x_a; ys = y_a; xe = x_b; ye = y_b;
    end
    if (xs == xe && ys > ye) begin
      ys = y_b > y_a ? y_a : y_b;
      ye = y_b > y_a ? y_b : y_a;
    end
    rising = ye >= ys;
    dx     = xe - xs;
    dy     = rising ? (ye - ys) : (ys - ye);
    dxe    = $signed({{(ERR_W-COORD_BITS){1'b0}}, dx});
    dye    = $signed({{(ERR_W-COORD_BITS){1'b0}}, dy});

    first_x = xs;
    first_y = ys;
    if (dx == '0) begin
      ctl.mode = mlr_pkg::MODE_VERT;
      stop     = ye;
      err      = '0;
    end else if (dy == '0) begin
      ctl.mode = mlr_pkg::MODE_HORZ;
      stop     = xe;
      err      = '0;
    end else if (dy <= dx) begin
      stop = xe;
      if (rising) begin
        ctl.mode = mlr_pkg::MODE_SHALLOW_UP;
        err      = (dye <<< 1) - dxe;
      end else begin
        ctl.mode = mlr_pkg::MODE_SHALLOW_DOWN;
        err      = dxe - (dye <<< 1);
      end
    end else begin
      stop = ye;
      if (rising) begin
        ctl.mode = mlr_pkg::MODE_STEEP_UP;
        err      = dye - (dxe <<< 1);
      end else begin
        ctl.mode = mlr_pkg::MODE_STEEP_DOWN;
        err      = (dxe <<< 1) - dye;
      end
    end
    // A single point is done at once
    ctl.last   = (dx == '0) && (dy == '0);
    ctl.active = !ctl.last;
  end

endmodule

`default_nettype wire

[design/mlr_step.sv]
`default_nettype none

module mlr_step #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned ERR_W      = 13
) (
  input  wire logic [COORD_BITS-1:0]   cur_x,
  input  wire logic [COORD_BITS-1:0]   cur_y,
  input  wire logic [COORD_BITS-1:0]   stop,
  input  wire logic [COORD_BITS-1:0]   dx,
  input  wire logic [COORD_BITS-1:0]   dy,
  input  wire logic signed [ERR_W-1:0] err,
  input  wire mlr_pkg::mode_t          mode,
  output logic [COORD_BITS-1:0]        next_x,
  output logic [COORD_BITS-1:0]        next_y,
  output logic signed [ERR_W-1:0]      next_err,
  output logic                         done
);

  logic signed [ERR_W-1:0] dxe, dye;
  logic                    nonneg;

  assign dxe    = $signed({{(ERR_W-COORD_BITS){1'b0}}, dx});
  assign dye    = $signed({{(ERR_W-COORD_BITS){1'b0}}, dy});
  assign nonneg = !err[ERR_W-1];

  always_comb begin
    next_x   = cur_x;
    next_y   = cur_y;
    next_err = err;
    case (mode)
      mlr_pkg::MODE_VERT: begin
        next_y = cur_y + 1'b1;
      end
      mlr_pkg::MODE_HORZ: begin
        next_x = cur_x + 1'b1;
      end
      mlr_pkg::MODE_SHALLOW_UP: begin
        if (nonneg) begin
          next_err = err + ((dye - dxe) <<< 1);
          next_y   = cur_y + 1'b1;
        end else begin
          next_err = err + (dye <<< 1);
        end
        next_x = cur_x + 1'b1;
      end
      mlr_pkg::MODE_SHALLOW_DOWN: begin
        if (nonneg) begin
          next_err = err - (dye <<< 1);
        end else begin
          next_err = err + ((dxe - dye) <<< 1);
          next_y   = cur_y - 1'b1;
        end
        next_x = cur_x + 1'b1;
      end
      mlr_pkg::MODE_STEEP_UP: begin
        if (nonneg) begin
          next_err = err - (dxe <<< 1);
        end else begin
          next_err = err + ((dye - dxe) <<< 1);
          next_x   = cur_x + 1'b1;
        end
        next_y = cur_y + 1'b1;
      end
      default: begin
        if (nonneg) begin
          next_err = err + ((dxe - dye) <<< 1);
          next_x   = cur_x + 1'b1;
        end else begin
          next_err = err + (dxe <<< 1);
        end
        next_y = cur_y - 1'b1;
      end
    endcase
    if (mode == mlr_pkg::MODE_VERT || mode == mlr_pkg::MODE_STEEP_UP ||
        mode == mlr_pkg::MODE_STEEP_DOWN) begin
      done = (next_y == stop);
    end else begin
      done = (next_x == stop);
    end
  end

endmodule

`default_nettype wire

[design/midpoint_line_rasterizer.sv]
// Midpoint line rasterizer, all octants, integer arithmetic only.
// Input channel (in_valid / in_stall): operation 0 loads a segment from
// x_start, y_start, x_end, y_end and returns its first pixel; operation 1
// returns the next pixel of the active segment, with last_pixel on the
// final one. A step with no active segment returns a result with
// pixel_valid low and all other fields zero. A start while a segment is
// active drops the old segment.
// Output channel (out_valid / out_stall): exactly one result per item.
// Path: an accepted item passes one input register, then the setup or
// step logic feeding the result register and the segment state in the
// same cycle; out_valid rises when the result register is loaded. One
// item is accepted per cycle while in_stall is low; the segment state
// updates in the cycle an item is processed, so the next item sees it
// without a bubble.
// When the receiver stalls, the result register holds and one more item
// waits in the input register; in_stall rises after that.
// Reset (rst, synchronous) empties both registers and leaves no active
// segment.
`default_nettype none

module midpoint_line_rasterizer #(
  parameter int unsigned COORD_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  operation,
  input  wire logic [COORD_BITS-1:0] x_start,
  input  wire logic [COORD_BITS-1:0] y_start,
  input  wire logic [COORD_BITS-1:0] x_end,
  input  wire logic [COORD_BITS-1:0] y_end,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COORD_BITS-1:0]      pixel_x,
  output logic [COORD_BITS-1:0]      pixel_y,
  output logic                       pixel_valid,
  output logic                       last_pixel
);

  localparam int unsigned ERR_W = COORD_BITS + mlr_pkg::ERR_EXTRA;

  // Input register
  logic                  hold_valid;
  mlr_pkg::op_t          hold_op;
  logic [COORD_BITS-1:0] hold_xa, hold_ya, hold_xb, hold_yb;

  // Segment state
  logic [COORD_BITS-1:0]   cur_x, cur_y, stop_coord, delta_x, delta_y;
  logic signed [ERR_W-1:0] err_term;
  mlr_pkg::mode_t          direction_mode;
  logic                    line_active;

  logic [COORD_BITS-1:0]   cur_x_next, cur_y_next, stop_coord_next;
  logic [COORD_BITS-1:0]   delta_x_next, delta_y_next;
  logic signed [ERR_W-1:0] err_term_next;
  mlr_pkg::mode_t          direction_mode_next;
  logic                    line_active_next;
  logic                    last_next, pixel_valid_next;

  logic [COORD_BITS-1:0]   su_x, su_y, su_stop, su_dx, su_dy;
  logic signed [ERR_W-1:0] su_err;
  mlr_pkg::seg_ctl_t       su_ctl;
  logic [COORD_BITS-1:0]   st_x, st_y;
  logic signed [ERR_W-1:0] st_err;
  logic                    st_done;

  logic advance;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      hold_op <= mlr_pkg::op_t'(operation);
      hold_xa <= x_start;
      hold_ya <= y_start;
      hold_xb <= x_end;
      hold_yb <= y_end;
    end
  end

  mlr_setup #(
    .COORD_BITS(COORD_BITS),
    .ERR_W     (ERR_W)
  ) u_setup (
    .x_a    (hold_xa),
    .y_a    (hold_ya),
    .x_b    (hold_xb),
    .y_b    (hold_yb),
    .first_x(su_x),
    .first_y(su_y),
    .stop   (su_stop),
    .dx     (su_dx),
    .dy     (su_dy),
    .err    (su_err),
    .ctl    (su_ctl)
  );

  mlr_step #(
    .COORD_BITS(COORD_BITS),
    .ERR_W     (ERR_W)
  ) u_step (
    .cur_x   (cur_x),
    .cur_y   (cur_y),
    .stop    (stop_coord),
    .dx      (delta_x),
    .dy      (delta_y),
    .err     (err_term),
    .mode    (direction_mode),
    .next_x  (st_x),
    .next_y  (st_y),
    .next_err(st_err),
    .done    (st_done)
  );

  always_comb begin
    cur_x_next          = cur_x;
    cur_y_next          = cur_y;
    stop_coord_next     = stop_coord;
    delta_x_next        = delta_x;
    delta_y_next        = delta_y;
    err_term_next       = err_term;
    direction_mode_next = direction_mode;
    line_active_next    = line_active;
    pixel_valid_next    = 1'b0;
    last_next           = 1'b0;
    if (hold_op == mlr_pkg::OP_START) begin
      cur_x_next          = su_x;
      cur_y_next          = su_y;
      stop_coord_next     = su_stop;
      delta_x_next        = su_dx;
      delta_y_next        = su_dy;
      err_term_next       = su_err;
      direction_mode_next = su_ctl.mode;
      line_active_next    = su_ctl.active;
      pixel_valid_next    = 1'b1;
      last_next           = su_ctl.last;
    end else if (line_active) begin
      cur_x_next       = st_x;
      cur_y_next       = st_y;
      err_term_next    = st_err;
      line_active_next = !st_done;
      pixel_valid_next = 1'b1;
      last_next        = st_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x          <= '0;
      cur_y          <= '0;
      stop_coord     <= '0;
      delta_x        <= '0;
      delta_y        <= '0;
      err_term       <= '0;
      direction_mode <= mlr_pkg::MODE_VERT;
      line_active    <= 1'b0;
      out_valid      <= 1'b0;
    end else if (advance) begin
      out_valid <= hold_valid;
      if (hold_valid) begin
        cur_x          <= cur_x_next;
        cur_y          <= cur_y_next;
        stop_coord     <= stop_coord_next;
        delta_x        <= delta_x_next;
        delta_y        <= delta_y_next;
        err_term       <= err_term_next;
        direction_mode <= direction_mode_next;
        line_active    <= line_active_next;
      end
    end
  end

  // Result register; an idle step shows all zero
  always_ff @(posedge clk) begin
    if (advance && hold_valid) begin
      pixel_x     <= pixel_valid_next ? cur_x_next : '0;
      pixel_y     <= pixel_valid_next ? cur_y_next : '0;
      pixel_valid <= pixel_valid_next;
      last_pixel  <= last_next;
    end
  end

endmodule

`default_nettype wire

[design/mlr_checker.sv]
`default_nettype none

module mlr_checker #(
  parameter int unsigned COORD_BITS = 10
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [COORD_BITS-1:0] pixel_x,
  input wire logic [COORD_BITS-1:0] pixel_y,
  input wire logic                  pixel_valid,
  input wire logic                  last_pixel
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present right after reset");

  // An empty result carries zeros and no last mark
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pixel_valid |-> pixel_x == '0 && pixel_y == '0 && !last_pixel)
    else $error("idle result is not all zero");

  // With the output free, the block never stalls its input
  a_no_stall_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output is empty");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(pixel_valid) && $stable(last_pixel))
    else $error("stalled result changed");

endmodule

bind midpoint_line_rasterizer mlr_checker #(.COORD_BITS(COORD_BITS)) u_mlr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .pixel_x    (pixel_x),
  .pixel_y    (pixel_y),
  .pixel_valid(pixel_valid),
  .last_pixel (last_pixel)
);

`default_nettype wire

[tb/tb_midpoint_line_rasterizer.sv]
`timescale 1ns / 100ps

module tb_midpoint_line_rasterizer;

  localparam int CB = 10;
  localparam int TOTAL_ITEMS = 850;
  localparam int CYCLE_LIMIT = 500_000;

  typedef struct {
    mlr_pkg::op_t  op;
    logic [CB-1:0] xs;
    logic [CB-1:0] ys;
    logic [CB-1:0] xe;
    logic [CB-1:0] ye;
  } cmd_t;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          valid;
    logic          last;
  } pixel_t;

  typedef struct {
    cmd_t   cmd;
    bit     fixed;
    pixel_t want;
  } row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          operation = 1'b0;
  logic [CB-1:0] x_start = '0;
  logic [CB-1:0] y_start = '0;
  logic [CB-1:0] x_end = '0;
  logic [CB-1:0] y_end = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [CB-1:0] pixel_x;
  logic [CB-1:0] pixel_y;
  logic          pixel_valid;
  logic          last_pixel;

  midpoint_line_rasterizer #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation),
    .x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .pixel_valid(pixel_valid), .last_pixel(last_pixel)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Segment state of the predictor
  logic [CB-1:0]  seg_x, seg_y, seg_stop;
  int             seg_err, seg_dx, seg_dy;
  mlr_pkg::mode_t seg_mode;
  bit             seg_live;

  pixel_t pending_pixels [$];
  int     faults = 0;
  int     sent = 0;
  int     cycles = 0;
  bit     calm = 1'b0;
  int     stall_left = 0;

  function automatic pixel_t trace_pixel(cmd_t c);
    pixel_t        p;
    logic [CB-1:0] xa, ya, xb, yb, t;
    bit            rising, done;
    p = '0;
    if (c.op == mlr_pkg::OP_START) begin
      xa = c.xs; ya = c.ys; xb = c.xe; yb = c.ye;
      if (xa > xb) begin
        t = xa; xa = xb; xb = t;
        t = ya; ya = yb; yb = t;
      end
      if (xa == xb && ya > yb) begin
        t = ya; ya = yb; yb = t;
      end
      seg_dx = int'(xb) - int'(xa);
      rising = (yb >= ya);
      seg_dy = rising ? int'(yb) - int'(ya) : int'(ya) - int'(yb);
      seg_x = xa;
      seg_y = ya;
      if (seg_dx == 0) begin
        seg_mode = mlr_pkg::MODE_VERT;  seg_stop = yb; seg_err = 0;
      end else if (seg_dy == 0) begin
        seg_mode = mlr_pkg::MODE_HORZ;  seg_stop = xb; seg_err = 0;
      end else if (seg_dy <= seg_dx) begin
        seg_stop = xb;
        seg_mode = rising ? mlr_pkg::MODE_SHALLOW_UP : mlr_pkg::MODE_SHALLOW_DOWN;
        seg_err  = rising ? 2 * seg_dy - seg_dx : seg_dx - 2 * seg_dy;
      end else begin
        seg_stop = yb;
        seg_mode = rising ? mlr_pkg::MODE_STEEP_UP : mlr_pkg::MODE_STEEP_DOWN;
        seg_err  = rising ? seg_dy - 2 * seg_dx : 2 * seg_dx - seg_dy;
      end
      seg_live = !(xa == xb && ya == yb);
      p = '{x: seg_x, y: seg_y, valid: 1'b1, last: !seg_live};
    end else if (seg_live) begin
      case (seg_mode)
        mlr_pkg::MODE_VERT: seg_y = seg_y + 1'b1;
        mlr_pkg::MODE_HORZ: seg_x = seg_x + 1'b1;
        mlr_pkg::MODE_SHALLOW_UP: begin
          if (seg_err >= 0) begin
            seg_err += 2 * (seg_dy - seg_dx);
            seg_y = seg_y + 1'b1;
          end else seg_err += 2 * seg_dy;
          seg_x = seg_x + 1'b1;
        end
        mlr_pkg::MODE_SHALLOW_DOWN: begin
          if (seg_err >= 0) seg_err -= 2 * seg_dy;
          else begin
            seg_err += 2 * (seg_dx - seg_dy);
            seg_y = seg_y - 1'b1;
          end
          seg_x = seg_x + 1'b1;
        end
        mlr_pkg::MODE_STEEP_UP: begin
          if (seg_err >= 0) seg_err -= 2 * seg_dx;
          else begin
            seg_err += 2 * (seg_dy - seg_dx);
            seg_x = seg_x + 1'b1;
          end
          seg_y = seg_y + 1'b1;
        end
        default: begin
          if (seg_err >= 0) begin
            seg_err += 2 * (seg_dx - seg_dy);
            seg_x = seg_x + 1'b1;
          end else seg_err += 2 * seg_dx;
          seg_y = seg_y - 1'b1;
        end
      endcase
      if (seg_mode == mlr_pkg::MODE_VERT || seg_mode == mlr_pkg::MODE_STEEP_UP ||
          seg_mode == mlr_pkg::MODE_STEEP_DOWN)
        done = (seg_y == seg_stop);
      else
        done = (seg_x == seg_stop);
      seg_live = !done;
      p = '{x: seg_x, y: seg_y, valid: 1'b1, last: done};
    end
    return p;
  endfunction

  // Mostly short gaps, a few long ones, none during a calm stretch
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CB-1:0] pick_coord();
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(0, 1) ? CB'($urandom_range(0, 7)) : CB'($urandom_range(1016, 1023));
    return CB'($urandom_range(0, 1023));
  endfunction

  function automatic logic [CB-1:0] nudge(logic [CB-1:0] v, int s);
    int t;
    t = int'(v) + int'($urandom_range(0, 2 * s)) - s;
    if (t < 0) t = 0;
    if (t > 1023) t = 1023;
    return t[CB-1:0];
  endfunction

  function automatic row_t row(mlr_pkg::op_t op, int xs, int ys, int xe, int ye,
                               bit fixed = 1'b0, int px = 0, int py = 0, bit pv = 1'b0,
                               bit pl = 1'b0);
    row_t r;
    r.cmd  = '{op: op, xs: CB'(xs), ys: CB'(ys), xe: CB'(xe), ye: CB'(ye)};
    r.fixed = fixed;
    r.want = '{x: CB'(px), y: CB'(py), valid: pv, last: pl};
    return r;
  endfunction

  task automatic issue(input cmd_t c, input bit fixed, input pixel_t want);
    int     gap;
    pixel_t p;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    operation = c.op;
    x_start   = c.xs;
    y_start   = c.ys;
    x_end     = c.xe;
    y_end     = c.ye;
    do @(posedge clk); while (in_stall);
    p = trace_pixel(c);
    pending_pixels = {pending_pixels, (fixed ? want : p)};
    sent++;
  endtask

  task automatic issue_step();
    cmd_t c;
    c = '{op: mlr_pkg::OP_STEP, xs: CB'($urandom), ys: CB'($urandom), xe: CB'($urandom),
          ye: CB'($urandom)};
    issue(c, 1'b0, '0);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
      if (!rst && !calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
    end
  end

  always @(posedge clk) begin
    pixel_t got, exp_px;
    if (!rst && out_valid && !out_stall) begin
      got = '{x: pixel_x, y: pixel_y, valid: pixel_valid, last: last_pixel};
      if (pending_pixels.size() == 0) begin
        if (faults < 10)
          $display("unexpected item: x=%0d y=%0d valid=%0b last=%0b",
                   got.x, got.y, got.valid, got.last);
        faults++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (got.x !== exp_px.x || got.y !== exp_px.y || got.valid !== exp_px.valid ||
            got.last !== exp_px.last) begin
          if (faults < 10)
            $display({"mismatch: expected x=%0d y=%0d valid=%0b last=%0b, ",
                      "got x=%0d y=%0d valid=%0b last=%0b"},
                     exp_px.x, exp_px.y, exp_px.valid, exp_px.last,
                     got.x, got.y, got.valid, got.last);
          faults++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    row_t          plan [$];
    cmd_t          c;
    logic [CB-1:0] xa, ya, xb, yb;
    int            kind, span, n, steps;
    seg_x = '0; seg_y = '0; seg_stop = '0;
    seg_err = 0; seg_dx = 0; seg_dy = 0;
    seg_mode = mlr_pkg::MODE_VERT; seg_live = 1'b0;

    plan = '{
      row(mlr_pkg::OP_STEP, 0, 0, 0, 0, 1, 0, 0, 0, 0),                // step after reset
      row(mlr_pkg::OP_START, 1023, 1023, 1023, 1023, 1, 1023, 1023, 1, 1),
      row(mlr_pkg::OP_START, 0, 0, 0, 0, 1, 0, 0, 1, 1),
      row(mlr_pkg::OP_STEP, 1023, 1023, 1023, 1023, 1, 0, 0, 0, 0),    // idle after point
      row(mlr_pkg::OP_START, 3, 9, 3, 7, 1, 3, 7, 1, 0),               // vertical, y swapped
      row(mlr_pkg::OP_STEP, 0, 0, 0, 0),
      row(mlr_pkg::OP_STEP, 0, 0, 0, 0),
      row(mlr_pkg::OP_START, 6, 7, 4, 7, 1, 4, 7, 1, 0),               // horizontal, swapped
      row(mlr_pkg::OP_STEP, 0, 0, 0, 0),
      row(mlr_pkg::OP_STEP, 0, 0, 0, 0),
      row(mlr_pkg::OP_START, 0, 0, 4, 2),                              // shallow rising, tie
      row(mlr_pkg::OP_STEP, 0, 0, 0, 0),
      row(mlr_pkg::OP_STEP, 0, 0, 0, 0),
      row(mlr_pkg::OP_STEP, 0, 0, 0, 0),
      row(mlr_pkg::OP_STEP, 0, 0, 0, 0),
      row(mlr_pkg::OP_START, 0, 1023, 1023, 0, 1, 0, 1023, 1, 0),      // full diagonal
      row(mlr_pkg::OP_START, 4, 0, 0, 2),                              // shallow falling
      row(mlr_pkg::OP_STEP, 0, 0, 0, 0),
      row(mlr_pkg::OP_START, 0, 0, 1, 2),                              // steep rising, tie
      row(mlr_pkg::OP_STEP, 0, 0, 0, 0),
      row(mlr_pkg::OP_STEP, 0, 0, 0, 0),
      row(mlr_pkg::OP_START, 1023, 1021, 1022, 1023),                  // steep falling
      row(mlr_pkg::OP_STEP, 0, 0, 0, 0),
      row(mlr_pkg::OP_STEP, 0, 0, 0, 0),
      row(mlr_pkg::OP_STEP, 0, 0, 0, 0, 1, 0, 0, 0, 0)
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) issue(plan[i].cmd, plan[i].fixed, plan[i].want);

    while (sent < TOTAL_ITEMS) begin
      kind = $urandom_range(0, 99);
      calm = ($urandom_range(0, 9) == 0);
      if (kind < 10) begin
        // noise: any operation, any payload
        c = '{op: mlr_pkg::op_t'($urandom_range(0, 1)), xs: CB'($urandom),
              ys: CB'($urandom), xe: CB'($urandom), ye: CB'($urandom)};
        issue(c, 1'b0, '0);
      end else begin
        if ($urandom_range(0, 19) == 0) begin
          xa = CB'($urandom); ya = CB'($urandom);
          xb = CB'($urandom); yb = CB'($urandom);
        end else begin
          span = $urandom_range(0, 16);
          xa = pick_coord(); ya = pick_coord();
          xb = nudge(xa, span); yb = nudge(ya, span);
        end
        n = (xa > xb) ? int'(xa) - int'(xb) : int'(xb) - int'(xa);
        span = (ya > yb) ? int'(ya) - int'(yb) : int'(yb) - int'(ya);
        if (span > n) n = span;
        if (n > 64) steps = $urandom_range(0, 48);
        else if (kind < 80) steps = n + (($urandom_range(0, 9) < 3) ? $urandom_range(1, 2) : 0);
        else steps = $urandom_range(0, n);
        c = '{op: mlr_pkg::OP_START, xs: xa, ys: ya, xe: xb, ye: yb};
        issue(c, 1'b0, '0);
        repeat (steps) issue_step();
      end
    end
    calm = 1'b0;
    @(negedge clk);
    in_valid = 1'b0;

    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (faults == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
